FILE: rtl/core/src_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// src_pkg
// Shared types, codes and helpers of the service rule classifier.
// ----------------------------------------------------------------------------
package src_pkg;

    localparam int MAX_RULES_DEF = 64;

    // stream widths
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLTHRU = 1'b1;

    // field widths
    localparam int KEY_W   = 16;
    localparam int MASK_W  = 5;
    localparam int RANK_W  = 3;
    localparam int ENTRY_W = 4 * KEY_W + KEY_W + MASK_W + 1;

    // request kinds
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // decisions
    localparam logic [1:0] DEC_DENY  = 2'd0;
    localparam logic [1:0] DEC_ALLOW = 2'd1;
    localparam logic [1:0] DEC_FALL  = 2'd2;

    // field mask bits
    localparam int FM_SID  = 0;
    localparam int FM_TSID = 1;
    localparam int FM_ONID = 2;
    localparam int FM_SAT  = 3;
    localparam int FM_FREQ = 4;

    localparam logic signed [RANK_W-1:0] RANK_NONE = -3'sd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_FINISH
    } t_state;

    // control from the sequencer to the match unit
    typedef struct packed {
        logic clear;
        logic en;
    } t_match_ctl;

    // running result of the match unit
    typedef struct packed {
        logic signed [RANK_W-1:0] best;
        logic                     any_ex;
    } t_match_stat;

    function automatic logic signed [RANK_W-1:0] rank_of(input logic [MASK_W-1:0] m);
        logic signed [RANK_W-1:0] r;
        if (m[FM_SID]) begin
            r = 3'sd3;
        end else if (m[FM_TSID] && m[FM_ONID]) begin
            r = 3'sd2;
        end else if (m[FM_FREQ]) begin
            r = 3'sd1;
        end else if (m[FM_SAT]) begin
            r = 3'sd0;
        end else begin
            r = RANK_NONE;
        end
        return r;
    endfunction

    // bouquet hits, then the auto setting
    function automatic logic [1:0] group_decide(input logic g_ex, input logic g_in,
                                                input logic auto_fall);
        logic [1:0] d;
        if (g_ex) begin
            d = DEC_DENY;
        end else if (g_in) begin
            d = DEC_ALLOW;
        end else if (auto_fall) begin
            d = DEC_FALL;
        end else begin
            d = DEC_DENY;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/service_rule_classifier_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// service_rule_classifier_top
// Rule table classifier of broadcast services by their five identifiers.
// ----------------------------------------------------------------------------
// results: append, clear, disabled and empty-table lookups give their result in the
//   cycle after the input transaction; a lookup runs S_SCAN, S_LAST, then S_FINISH
// the single read port of the rule RAM feeds one rule a cycle to the match unit
// throughput: one item at a time, s_axis_tready returns once the result is taken
// reset: synchronous active low; clears rule count, sequencer and output valid,
//   enable to 0 and auto_fallthrough to 1; rule RAM contents are left as is
module service_rule_classifier_top #(
    parameter int MAX_RULES = src_pkg::MAX_RULES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [src_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [src_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // service_id, stream_id, network_id, orbit_pos, freq_id, field_mask,
    // include_rule, group_incl_hit, group_excl_hit
    input  wire logic [src_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic [src_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // decision, winning_rank, table_full, zero pad
    output logic [src_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import src_pkg::*;

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);

    // input fields
    logic [1:0]         w_req;
    logic [4*KEY_W-1:0] w_key;
    logic [KEY_W-1:0]   w_orbit;
    logic [MASK_W-1:0]  w_mask;
    logic               w_incl;
    logic               w_g_in;
    logic               w_g_ex;

    assign w_req   = s_axis_tuser;
    assign w_key   = {s_axis_tdata[79:64], s_axis_tdata[47:0]};
    assign w_orbit = s_axis_tdata[63:48];
    assign w_mask  = s_axis_tdata[84:80];
    assign w_incl  = s_axis_tdata[85];
    assign w_g_in  = s_axis_tdata[86];
    assign w_g_ex  = s_axis_tdata[87];

    // configuration registers
    logic r_enable;
    logic r_auto;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_auto   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:   r_enable <= i_cfg_data[0];
                CFG_FALLTHRU: r_auto   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshakes
    t_state r_state;
    t_state n_state;
    logic   w_in_acc;
    logic   w_out_acc;
    logic   r_out_vld;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = r_out_vld && m_axis_tready;

    // rule count and scan index
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_idx;
    logic          w_full;
    logic          w_scan_go;
    logic          w_scan_last;

    assign w_full      = (r_count == CW'(MAX_RULES));
    assign w_scan_go   = (w_req == REQ_LOOKUP) && r_enable && (r_count != '0);
    assign w_scan_last = ((CW'(r_idx) + CW'(1)) == r_count);

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_scan_go) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_scan_last) n_state = S_LAST;
            end
            S_LAST:   n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // sequencer: outputs
    logic       w_scan_step;
    logic       w_finish;
    logic       r_rd_vld;
    t_match_ctl w_ctl;

    always_comb begin
        s_axis_tready = 1'b0;
        w_scan_step   = 1'b0;
        w_finish      = 1'b0;
        case (r_state)
            S_IDLE:   s_axis_tready = !r_out_vld;
            S_SCAN:   w_scan_step   = 1'b1;
            S_LAST:   ;
            S_FINISH: w_finish      = 1'b1;
            default:  ;
        endcase
        w_ctl.clear = w_in_acc;
        w_ctl.en    = r_rd_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_count  <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_scan_step;
            if (w_in_acc) begin
                r_idx <= '0;
            end else if (w_scan_step) begin
                r_idx <= r_idx + AW'(1);
            end
            if (w_in_acc && (w_req == REQ_APPEND) && !w_full) begin
                r_count <= r_count + CW'(1);
            end else if (w_in_acc && (w_req == REQ_CLEAR)) begin
                r_count <= '0;
            end
        end
    end

    // lookup operands, held through the scan
    logic [4*KEY_W-1:0] r_key;
    logic [KEY_W-1:0]   r_orbit;
    logic               r_g_in;
    logic               r_g_ex;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_key   <= w_key;
            r_orbit <= w_orbit;
            r_g_in  <= w_g_in;
            r_g_ex  <= w_g_ex;
        end
    end

    // rule store
    logic               w_we;
    logic [ENTRY_W-1:0] w_wentry;
    logic [ENTRY_W-1:0] w_rentry;

    assign w_we     = w_in_acc && (w_req == REQ_APPEND) && !w_full;
    assign w_wentry = {w_incl, w_mask, w_orbit, w_key};

    src_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (MAX_RULES),
        .ADDR_W (AW)
    ) u_rule_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wentry),
        .i_raddr (r_idx),
        .o_rdata (w_rentry)
    );

    t_match_stat w_stat;

    src_match_unit u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_key   (r_key),
        .i_orbit (r_orbit),
        .i_entry (w_rentry),
        .o_stat  (w_stat)
    );

    // result register
    logic                     w_direct;
    logic [1:0]               w_dec;
    logic signed [RANK_W-1:0] w_rank;
    logic                     w_tfull;
    logic [1:0]               r_dec;
    logic [RANK_W-1:0]        r_rank;
    logic                     r_tfull;

    assign w_direct = w_in_acc && !w_scan_go;

    always_comb begin
        w_dec   = DEC_DENY;
        w_rank  = RANK_NONE;
        w_tfull = 1'b0;
        if (w_finish) begin
            // scan complete: ranked rule wins, otherwise bouquets and auto
            if (w_stat.best >= 3'sd0) begin
                w_rank = w_stat.best;
                w_dec  = w_stat.any_ex ? DEC_DENY : DEC_ALLOW;
            end else begin
                w_dec = group_decide(r_g_ex, r_g_in, r_auto);
            end
        end else begin
            // enabled lookup on an empty table goes straight to the bouquets
            if ((w_req == REQ_LOOKUP) && r_enable) begin
                w_dec = group_decide(w_g_ex, w_g_in, r_auto);
            end
            w_tfull = (w_req == REQ_APPEND) && w_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_direct || w_finish) begin
            r_out_vld <= 1'b1;
        end else if (w_out_acc) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_direct || w_finish) begin
            r_dec   <= w_dec;
            r_rank  <= w_rank;
            r_tfull <= w_tfull;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_tfull, r_rank, r_dec};

`ifndef SYNTH
    // the table never holds more rules than it has room for
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RULES))
        else $error("rule count beyond table size");

    // an enabled lookup on a non-empty table starts a scan
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_scan_go) |=> (r_state == S_SCAN))
        else $error("lookup did not start scan");

    // a finished scan always leaves a result waiting
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |=> m_axis_tvalid)
        else $error("scan finished without result");

    // no new transaction is taken while a result or a scan is pending
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!r_out_vld && (r_state == S_IDLE)))
        else $error("ready while busy");

    // the rule RAM is not written during a scan
    a_no_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_we)
        else $error("rule write during scan");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/src_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// src_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module src_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/src_match_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// src_match_unit
// Compares one stored rule a cycle with the looked-up service and keeps the
// best rank seen so far and whether an exclude rule holds that rank.
// ----------------------------------------------------------------------------
module src_match_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire src_pkg::t_match_ctl         i_ctl,
    input  wire logic [4*src_pkg::KEY_W-1:0] i_key,
    input  wire logic [src_pkg::KEY_W-1:0]   i_orbit,
    input  wire logic [src_pkg::ENTRY_W-1:0] i_entry,
    output src_pkg::t_match_stat             o_stat
);
    import src_pkg::*;

    logic [4*KEY_W-1:0]       w_rkey;
    logic [KEY_W-1:0]         w_rorbit;
    logic [MASK_W-1:0]        w_mask;
    logic                     w_incl;
    logic                     w_hit;
    logic signed [RANK_W-1:0] w_rank;
    logic signed [RANK_W-1:0] r_best;
    logic signed [RANK_W-1:0] n_best;
    logic                     r_any_ex;
    logic                     n_any_ex;

    // entry layout: keys, orbit, mask, include bit
    assign w_rkey   = i_entry[4*KEY_W-1:0];
    assign w_rorbit = i_entry[5*KEY_W-1:4*KEY_W];
    assign w_mask   = i_entry[5*KEY_W+MASK_W-1:5*KEY_W];
    assign w_incl   = i_entry[ENTRY_W-1];

    always_comb begin
        w_hit = 1'b1;
        if (w_mask[FM_SID]  && (w_rkey[15:0]  != i_key[15:0]))  w_hit = 1'b0;
        if (w_mask[FM_TSID] && (w_rkey[31:16] != i_key[31:16])) w_hit = 1'b0;
        if (w_mask[FM_ONID] && (w_rkey[47:32] != i_key[47:32])) w_hit = 1'b0;
        if (w_mask[FM_SAT]  && (w_rorbit      != i_orbit))      w_hit = 1'b0;
        if (w_mask[FM_FREQ] && (w_rkey[63:48] != i_key[63:48])) w_hit = 1'b0;
        w_rank = rank_of(w_mask);
    end

    always_comb begin
        n_best   = r_best;
        n_any_ex = r_any_ex;
        if (i_ctl.clear) begin
            n_best   = RANK_NONE;
            n_any_ex = 1'b0;
        end else if (i_ctl.en && w_hit && (w_rank >= 3'sd0) && (w_rank >= r_best)) begin
            if (w_rank > r_best) begin
                n_best   = w_rank;
                n_any_ex = !w_incl;
            end else begin
                n_any_ex = r_any_ex || !w_incl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best   <= RANK_NONE;
            r_any_ex <= 1'b0;
        end else begin
            r_best   <= n_best;
            r_any_ex <= n_any_ex;
        end
    end

    assign o_stat.best   = r_best;
    assign o_stat.any_ex = r_any_ex;

endmodule
`default_nettype wire

FILE: bench/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the service rule classifier. A driver feeds append,
// clear, lookup and unused requests from a queue, a local rule table predicts
// every verdict, and a monitor compares each result transaction field by field.
// ----------------------------------------------------------------------------
module tb;

    import src_pkg::*;

    localparam int TABLE_DEPTH = MAX_RULES_DEF;
    localparam int ITEM_GOAL   = 850;
    localparam int STALL_LIMIT = 5000;
    localparam int PRESSURE_AT = 150;
    localparam int HOLD_CYCLES = 300;

    // request code that the block ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // one request, field for field as it travels on the input stream
    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] sid;
        logic [15:0] tsid;
        logic [15:0] onid;
        logic [15:0] orbit;
        logic [15:0] freq;
        logic [4:0]  mask;
        logic        incl;
        logic        g_in;
        logic        g_ex;
    } t_item;

    // one verdict, as it comes back on the result stream
    typedef struct packed {
        logic [1:0] dec;
        logic [2:0] rank;
        logic       full;
    } t_verdict;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // configuration port, idle from time zero
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // input stream
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;

    // result stream
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    service_rule_classifier_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_item    pending_items[$];      // requests not yet taken by the block
    t_verdict expected_verdicts[$];  // verdicts of accepted requests, oldest first

    // local copy of the rule table and the two registers
    t_item rule_tab[TABLE_DEPTH];
    int    rule_cnt;
    logic  cfg_enable   = 1'b0;
    logic  cfg_fallthru = 1'b1;

    bit no_idle = 1'b0;              // stretch with no gaps on either side
    int items_queued;
    int n_fail;

    // tallies for the closing summary
    int n_results, n_lookup, n_allow, n_fall, n_ranked, n_full;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int rule_rank(input logic [MASK_W-1:0] m);
        if (m[FM_SID]) return 3;
        if (m[FM_TSID] && m[FM_ONID]) return 2;
        if (m[FM_FREQ]) return 1;
        if (m[FM_SAT]) return 0;
        return -1;
    endfunction

    // every key present in the rule must equal the service's key
    function automatic bit rule_hit(input t_item r, input t_item s);
        if (r.mask[FM_SID] && r.sid != s.sid) return 1'b0;
        if (r.mask[FM_TSID] && r.tsid != s.tsid) return 1'b0;
        if (r.mask[FM_ONID] && r.onid != s.onid) return 1'b0;
        if (r.mask[FM_SAT] && r.orbit != s.orbit) return 1'b0;
        if (r.mask[FM_FREQ] && r.freq != s.freq) return 1'b0;
        return 1'b1;
    endfunction

    // applies one accepted request to the local table and returns its verdict
    function automatic t_verdict classify(input t_item it);
        t_verdict v;
        int       best;
        bit       veto;
        int       r;
        v.dec  = DEC_DENY;
        v.rank = RANK_NONE;
        v.full = 1'b0;
        case (it.req)
            REQ_APPEND: begin
                if (rule_cnt >= TABLE_DEPTH) begin
                    v.full = 1'b1;
                end else begin
                    rule_tab[rule_cnt] = it;
                    rule_cnt++;
                end
            end
            REQ_CLEAR: begin
                rule_cnt = 0;
            end
            REQ_LOOKUP: begin
                if (cfg_enable) begin
                    best = -1;
                    veto = 1'b0;
                    for (int i = 0; i < rule_cnt; i++) begin
                        if (!rule_hit(rule_tab[i], it)) continue;
                        r = rule_rank(rule_tab[i].mask);
                        if (r < 0 || r < best) continue;
                        if (r > best) begin
                            best = r;
                            veto = 1'b0;
                        end
                        // an exclude rule of the top rank wins the tie
                        if (!rule_tab[i].incl) veto = 1'b1;
                    end
                    if (best >= 0) begin
                        v.rank = best[2:0];
                        v.dec  = veto ? DEC_DENY : DEC_ALLOW;
                    end else if (it.g_ex) begin
                        v.dec = DEC_DENY;
                    end else if (it.g_in) begin
                        v.dec = DEC_ALLOW;
                    end else begin
                        v.dec = cfg_fallthru ? DEC_FALL : DEC_DENY;
                    end
                end
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [IN_DATA_W-1:0] pack_item(input t_item it);
        return {it.g_ex, it.g_in, it.incl, it.mask, it.freq, it.orbit,
                it.onid, it.tsid, it.sid};
    endfunction

    function automatic t_item make_item(input logic [1:0] req, input logic [15:0] sid,
                                        input logic [15:0] tsid, input logic [15:0] onid,
                                        input logic [15:0] orbit, input logic [15:0] freq,
                                        input logic [4:0] mask, input logic incl,
                                        input logic g_in, input logic g_ex);
        t_item it;
        it.req   = req;
        it.sid   = sid;
        it.tsid  = tsid;
        it.onid  = onid;
        it.orbit = orbit;
        it.freq  = freq;
        it.mask  = mask;
        it.incl  = incl;
        it.g_in  = g_in;
        it.g_ex  = g_ex;
        return it;
    endfunction

    function automatic void queue_item(input t_item it);
        pending_items.insert(pending_items.size(), it);
        if (it.req != REQ_UNUSED) items_queued++;
    endfunction

    // most gaps short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // small alphabet so that rules and lookups collide often
    function automatic logic [15:0] pool_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, 3));
        if (r < 80) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pool_orbit();
        case ($urandom_range(0, 6))
            0: return 16'h8000;    // far west
            1: return 16'h7FFF;    // far east
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h00C0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_item random_rule();
        t_item it;
        it.req   = REQ_APPEND;
        it.sid   = pool_key();
        it.tsid  = pool_key();
        it.onid  = pool_key();
        it.orbit = pool_orbit();
        it.freq  = pool_key();
        // single-key rules keep the lower ranks in play
        it.mask  = ($urandom_range(0, 2) == 0) ? 5'(1 << $urandom_range(0, 4))
                                                : 5'($urandom_range(0, 31));
        it.incl  = 1'($urandom_range(0, 1));
        it.g_in  = 1'($urandom_range(0, 1));
        it.g_ex  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // a lookup near one of the given rules, or from the pools
    function automatic t_item lookup_near(ref t_item pool[$]);
        t_item it;
        it = random_rule();
        if (pool.size() > 0 && $urandom_range(0, 4) != 0) begin
            it = pool[$urandom_range(0, pool.size() - 1)];
            if ($urandom_range(0, 3) == 0) it.sid   = pool_key();
            if ($urandom_range(0, 3) == 0) it.tsid  = pool_key();
            if ($urandom_range(0, 3) == 0) it.onid  = pool_key();
            if ($urandom_range(0, 3) == 0) it.orbit = pool_orbit();
            if ($urandom_range(0, 3) == 0) it.freq  = pool_key();
            it.mask = 5'($urandom);
            it.incl = 1'($urandom_range(0, 1));
        end
        it.req  = REQ_LOOKUP;
        it.g_in = 1'($urandom_range(0, 1));
        it.g_ex = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_item noise_item();
        t_item it;
        it = t_item'({$urandom, $urandom, $urandom});
        return it;
    endfunction

    // wait until the block has nothing in flight; every request yields a
    // result, so an empty expectation queue means the block is idle
    task automatic drain();
        while (pending_items.size() != 0 || expected_verdicts.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // both registers, back to back, while the block is idle
    task automatic set_cfg(input logic en, input logic au);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ENABLE;
        i_cfg_data <= en;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FALLTHRU;
        i_cfg_data <= au;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_enable   = en;
        cfg_fallthru = au;
    endtask

    // ------------------------------------------------------------------------
    // driver: offers the head of the pending queue, predicts on acceptance
    // ------------------------------------------------------------------------
    bit drv_took;
    int tx_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            drv_took = s_axis_tvalid && s_axis_tready;
            if (drv_took) begin
                expected_verdicts.insert(expected_verdicts.size(),
                                         classify(pending_items.pop_front()));
                tx_gap = no_idle ? 0 : pick_gap();
            end
            // an offered transaction stays put until it is taken
            if (!s_axis_tvalid || drv_took) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pack_item(pending_items[0]);
                    s_axis_tuser  <= pending_items[0].req;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // long hold-off of the receiver, counted on its own
    // ------------------------------------------------------------------------
    int hold_cnt = 0;
    bit held     = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (!held && n_results >= PRESSURE_AT && pending_items.size() > 0) begin
            // hold off once while the sender still has work, so the block backs up
            held     <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, field checks
    // ------------------------------------------------------------------------
    bit       mon_took;
    int       rx_gap   = 0;
    t_verdict want;
    t_verdict got;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            mon_took = m_axis_tvalid && m_axis_tready;
            if (mon_took) begin
                got.dec  = m_axis_tdata[1:0];
                got.rank = m_axis_tdata[4:2];
                got.full = m_axis_tdata[5];
                n_results++;
                if (expected_verdicts.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    n_fail++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.dec != want.dec) begin
                        $error("decision: expected %0d, actual %0d", want.dec, got.dec);
                        n_fail++;
                    end
                    if (got.rank != want.rank) begin
                        $error("winning_rank: expected %0d, actual %0d",
                               $signed(want.rank), $signed(got.rank));
                        n_fail++;
                    end
                    if (got.full != want.full) begin
                        $error("table_full: expected %0d, actual %0d", want.full, got.full);
                        n_fail++;
                    end
                    if (want.dec == DEC_ALLOW) n_allow++;
                    if (want.dec == DEC_FALL) n_fall++;
                    if (want.rank != RANK_NONE) n_ranked++;
                    if (want.full) n_full++;
                end
                rx_gap = no_idle ? 0 : pick_gap();
            end
            if (hold_cnt > 0) begin
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // lookup tallies are taken where requests are accepted
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_LOOKUP) begin
            n_lookup++;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with no transaction of any kind
    // ------------------------------------------------------------------------
    int stall_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cnt = 0;
        end else begin
            stall_cnt++;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequencer: directed requests, then random phases
    // ------------------------------------------------------------------------
    t_item phase_rules[$];

    initial begin
        int n_rules;
        int n_looks;
        int r;
        t_item it;

        rule_cnt     = 0;
        items_queued = 0;
        n_fail       = 0;
        n_results    = 0;
        n_lookup     = 0;
        n_allow      = 0;
        n_fall       = 0;
        n_ranked     = 0;
        n_full       = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // straight out of reset the feature is off: lookups deny
        queue_item(make_item(REQ_APPEND, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 5'b00001, 1'b1, 1'b0, 1'b0));
        queue_item(make_item(REQ_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 5'b00000, 1'b0, 1'b1, 1'b0));
        drain();
        set_cfg(1'b1, 1'b1);
        @(negedge i_clk);

        queue_item(make_item(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 5'b11111, 1'b1, 1'b1, 1'b1));
        // empty mask is stored but never counts
        queue_item(make_item(REQ_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 5'b00000, 1'b1, 1'b1, 1'b1));
        queue_item(make_item(REQ_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 5'b00000, 1'b0, 1'b0, 1'b0));
        // bouquet bits: exclude beats include
        queue_item(make_item(REQ_LOOKUP, 16'h1234, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 5'b00000, 1'b0, 1'b1, 1'b1));
        queue_item(make_item(REQ_LOOKUP, 16'h1234, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 5'b00000, 1'b0, 1'b1, 1'b0));
        // service id rule, then an exclude twin wins the tie
        queue_item(make_item(REQ_APPEND, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 5'b00001, 1'b1, 1'b0, 1'b0));
        queue_item(make_item(REQ_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 5'b00000, 1'b0, 1'b0, 1'b1));
        queue_item(make_item(REQ_APPEND, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 5'b00001, 1'b0, 1'b0, 1'b0));
        queue_item(make_item(REQ_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 5'b00000, 1'b0, 1'b1, 1'b0));
        // transport plus network rank
        queue_item(make_item(REQ_APPEND, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
                             16'h0000, 5'b00110, 1'b1, 1'b0, 1'b0));
        queue_item(make_item(REQ_LOOKUP, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
                             16'h0000, 5'b00000, 1'b0, 1'b0, 1'b0));
        // frequency rank over an exclude on satellite position
        queue_item(make_item(REQ_APPEND, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                             16'hFFFF, 5'b10000, 1'b1, 1'b0, 1'b0));
        queue_item(make_item(REQ_APPEND, 16'h0000, 16'h0000, 16'h0000, 16'h8000,
                             16'h0000, 5'b01000, 1'b0, 1'b0, 1'b0));
        queue_item(make_item(REQ_LOOKUP, 16'h0001, 16'h0001, 16'h0001, 16'h8000,
                             16'hFFFF, 5'b00000, 1'b0, 1'b0, 1'b0));
        queue_item(make_item(REQ_LOOKUP, 16'h0001, 16'h0001, 16'h0001, 16'h8000,
                             16'h0000, 5'b00000, 1'b0, 1'b1, 1'b0));
        queue_item(make_item(REQ_LOOKUP, 16'h0001, 16'h0001, 16'h0001, 16'h7FFF,
                             16'h0001, 5'b00000, 1'b0, 1'b0, 1'b0));
        // unused request code is ignored
        queue_item(make_item(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 5'b11111, 1'b1, 1'b1, 1'b1));
        // every key present, all zero
        queue_item(make_item(REQ_APPEND, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 5'b11111, 1'b0, 1'b1, 1'b1));
        queue_item(make_item(REQ_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 5'b11111, 1'b1, 1'b0, 1'b0));
        drain();
        // unmatched lookup with auto off denies
        set_cfg(1'b1, 1'b0);
        @(negedge i_clk);
        queue_item(make_item(REQ_LOOKUP, 16'h7777, 16'h7777, 16'h7777, 16'h7777,
                             16'h7777, 5'b00000, 1'b0, 1'b0, 1'b0));
        drain();
        set_cfg(1'b1, 1'b1);

        // random phases until enough requests have gone out
        while (items_queued < ITEM_GOAL) begin
            if ($urandom_range(0, 2) == 0) begin
                r = $urandom_range(0, 5);
                case (r)
                    0: set_cfg(1'b0, 1'b1);
                    1: set_cfg(1'b0, 1'b0);
                    2: set_cfg(1'b1, 1'b0);
                    default: set_cfg(1'b1, 1'b1);
                endcase
            end
            no_idle = ($urandom_range(0, 3) == 0);
            @(negedge i_clk);
            phase_rules.delete();

            if ($urandom_range(0, 4) != 0) begin
                // well-formed: clear (in most phases), fill with rules, then look services up
                if ($urandom_range(0, 5) != 0) queue_item(make_item(REQ_CLEAR,
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 5'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                r = $urandom_range(0, 99);
                if (r < 85) n_rules = $urandom_range(1, 12);
                else if (r < 95) n_rules = $urandom_range(20, 40);
                else n_rules = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 4);
                for (int i = 0; i < n_rules; i++) begin
                    it = random_rule();
                    phase_rules.insert(phase_rules.size(), it);
                    queue_item(it);
                end
                n_looks = $urandom_range(3, 10);
                for (int i = 0; i < n_looks; i++) begin
                    queue_item(lookup_near(phase_rules));
                    // a late rule now and then
                    if ($urandom_range(0, 7) == 0) begin
                        it = random_rule();
                        phase_rules.insert(phase_rules.size(), it);
                        queue_item(it);
                    end
                end
            end else begin
                // noise: any code, any content
                n_looks = $urandom_range(3, 12);
                for (int i = 0; i < n_looks; i++) begin
                    queue_item(noise_item());
                end
            end
            drain();
        end

        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d result transactions, %0d lookups, %0d allowed, %0d fell through",
                 n_results, n_lookup, n_allow, n_fall);
        $display("ranked verdicts %0d, appends dropped on a full table %0d",
                 n_ranked, n_full);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
